@@ rtl/tsir_pkg.sv @@
// ----------------------------------------------------------------------------
// tsir_pkg: shared types and constants of the touch-strip I2C reader
// Holds the request codes, the event codes, the register indexes and the
// structs that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package tsir_pkg;

  // Input request kinds, carried on s_tuser.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Touch event codes reported with a finished transaction.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_TOUCH   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_REGISTER_INDEX = 2'd1;
  localparam logic [1:0] REG_DELAY_TICKS    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'h15;
  localparam logic [7:0]  REGISTER_INDEX_RESET = 8'h00;
  localparam logic [15:0] DELAY_TICKS_RESET    = 16'd30;

  // Number of read bytes that are kept for the result.
  localparam int KEPT_BYTES = 3;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [7:0]  register_index;
    logic [15:0] delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] touch_event;
    logic [7:0] extra_byte;
    logic [7:0] position_byte;
    logic [7:0] status_byte;
    logic       status;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } res_t;

endpackage

@@ rtl/touch_strip_i2c_reader.sv @@
// ----------------------------------------------------------------------------
// touch_strip_i2c_reader: I2C master for one fixed touch-strip register read
// Runs START, address+write, register byte, repeated START, address+read,
// the read bytes and STOP, one bus delay unit per line change, and reports
// touch and release events from the first byte read.
// ----------------------------------------------------------------------------
//  Channel  Direction  Width  Contents (lowest bit first)
//  s_*      in         8+1    tdata: sda_in; tuser: op (0 tick, 1 start)
//  m_*      out        32     tdata: scl/sda release, busy, done, status,
//                             status, position, extra bytes, touch event
//  cfg_*    in         2+16   register index and write data, no read-back
//
//  One tick advances the bus sequencer by one delay count, so a request can be
//  accepted on every cycle while no result is held back by m_tready.
//  The result of a request sits in the output register in the cycle after it is
//  accepted; a new request is taken while that result waits, as long as the
//  downstream side takes the held result in the same cycle.
//  When m_tready is low and a result is held, s_tready drops and nothing moves.
//  rst is synchronous and active high; it restores the register defaults,
//  releases both lines and empties the output register.
// ----------------------------------------------------------------------------
module touch_strip_i2c_reader
  import tsir_pkg::*;
#(
  parameter int READ_BYTES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] sda_in, [7:1] zero
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] scl_release, [1] sda_release, [2] busy_res,
                                 // [3] done_res, [4] status, [12:5] status_byte,
                                 // [20:13] position_byte, [28:21] extra_byte,
                                 // [30:29] touch_event, [31] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic step;

  // A request is accepted whenever the output register is empty or drains now.
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= DEVICE_ADDRESS_RESET;
      cfg.register_index <= REGISTER_INDEX_RESET;
      cfg.delay_ticks    <= DELAY_TICKS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEVICE_ADDRESS) begin
        cfg.device_address <= cfg_data[6:0];
      end else if (cfg_index == REG_REGISTER_INDEX) begin
        cfg.register_index <= cfg_data[7:0];
      end else if (cfg_index == REG_DELAY_TICKS) begin
        cfg.delay_ticks <= cfg_data;
      end
    end
  end

  tsir_seq #(
    .READ_BYTES(READ_BYTES)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .op     (s_tuser),
    .sda_in (s_tdata[0]),
    .cfg    (cfg),
    .res    (res)
  );

  // Output register: valid is control state, the payload loads on each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res};

endmodule

@@ rtl/tsir_seq.sv @@
// ----------------------------------------------------------------------------
// tsir_seq: bus sequencer of the touch-strip I2C reader
// Holds the transaction state and advances it by one request per step.
// ----------------------------------------------------------------------------
module tsir_seq
  import tsir_pkg::*;
#(
  parameter int READ_BYTES = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic op,
  input  logic sda_in,
  input  cfg_t cfg,
  output res_t res
);

  localparam int RIW = $clog2(READ_BYTES + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START1, ST_WBITS, ST_WACK, ST_START2, ST_RBITS, ST_RACK, ST_STOP
  } stage_t;

  stage_t           stage, stage_next;
  logic [1:0]       phase_step, phase_step_next;
  logic [2:0]       bit_count, bit_count_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [RIW-1:0]   read_index, read_index_next;
  logic [15:0]      delay_count, delay_count_next;
  logic [7:0]       captured [KEPT_BYTES];
  logic [7:0]       captured_next [KEPT_BYTES];
  logic             touching, touching_next;
  logic             scl_lvl, scl_lvl_next;
  logic             sda_lvl, sda_lvl_next;
  logic [1:0]       write_sel, write_sel_next;
  logic             nack_seen, nack_seen_next;
  logic             last_status, last_status_next;
  logic             done_now;
  logic [1:0]       event_now;
  logic [16:0]      count_inc;
  logic [15:0]      limit;

  // Byte sent in a write phase: address with write bit, register pointer,
  // then address with read bit.
  function automatic logic [7:0] write_byte(input logic [1:0] sel, input cfg_t c);
    logic [7:0] b;
    if (sel == 2'd0) begin
      b = {c.device_address, 1'b0};
    end else if (sel == 2'd1) begin
      b = c.register_index;
    end else begin
      b = {c.device_address, 1'b1};
    end
    return b;
  endfunction

  assign limit     = (cfg.delay_ticks == 16'd0) ? 16'd1 : cfg.delay_ticks;
  assign count_inc = {1'b0, delay_count} + 17'd1;

  always_comb begin
    stage_next       = stage;
    phase_step_next  = phase_step;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    read_index_next  = read_index;
    delay_count_next = delay_count;
    captured_next    = captured;
    touching_next    = touching;
    scl_lvl_next     = scl_lvl;
    sda_lvl_next     = sda_lvl;
    write_sel_next   = write_sel;
    nack_seen_next   = nack_seen;
    last_status_next = last_status;
    done_now         = 1'b0;
    event_now        = EV_NONE;

    if (op == OP_START) begin
      if (stage == ST_IDLE) begin
        for (int i = 0; i < KEPT_BYTES; i++) begin
          captured_next[i] = 8'd0;
        end
        write_sel_next   = 2'd0;
        nack_seen_next   = 1'b0;
        read_index_next  = '0;
        bit_count_next   = 3'd7;
        shift_byte_next  = 8'd0;
        delay_count_next = 16'd0;
        stage_next       = ST_START1;
        phase_step_next  = 2'd0;
        scl_lvl_next     = 1'b1;
        sda_lvl_next     = 1'b1;
      end
    end else if (stage != ST_IDLE) begin
      if (count_inc < {1'b0, limit}) begin
        delay_count_next = count_inc[15:0];
      end else begin
        delay_count_next = 16'd0;
        unique case (stage)
          ST_START1, ST_START2: begin
            if (phase_step == 2'd0) begin
              sda_lvl_next    = 1'b0;
              phase_step_next = 2'd1;
            end else if (phase_step == 2'd1) begin
              scl_lvl_next    = 1'b0;
              phase_step_next = 2'd2;
            end else begin
              shift_byte_next = write_byte(write_sel, cfg);
              bit_count_next  = 3'd7;
              stage_next      = ST_WBITS;
              phase_step_next = 2'd0;
              sda_lvl_next    = shift_byte_next[7];
            end
          end
          ST_WBITS: begin
            if (phase_step == 2'd0) begin
              scl_lvl_next    = 1'b1;
              phase_step_next = 2'd1;
            end else if (phase_step == 2'd1) begin
              scl_lvl_next    = 1'b0;
              phase_step_next = 2'd2;
            end else if (bit_count == 3'd0) begin
              stage_next      = ST_WACK;
              phase_step_next = 2'd0;
              sda_lvl_next    = 1'b1;
            end else begin
              bit_count_next  = bit_count - 3'd1;
              phase_step_next = 2'd0;
              sda_lvl_next    = shift_byte[bit_count_next];
            end
          end
          ST_WACK: begin
            if (phase_step == 2'd0) begin
              scl_lvl_next    = 1'b1;
              phase_step_next = 2'd1;
            end else if (phase_step == 2'd1) begin
              if (sda_in) begin
                nack_seen_next = 1'b1;
              end
              scl_lvl_next    = 1'b0;
              phase_step_next = 2'd2;
            end else if (nack_seen) begin
              stage_next      = ST_STOP;
              phase_step_next = 2'd0;
              sda_lvl_next    = 1'b0;
            end else if (write_sel == 2'd0) begin
              write_sel_next  = 2'd1;
              shift_byte_next = write_byte(2'd1, cfg);
              bit_count_next  = 3'd7;
              stage_next      = ST_WBITS;
              phase_step_next = 2'd0;
              sda_lvl_next    = shift_byte_next[7];
            end else if (write_sel == 2'd1) begin
              write_sel_next  = 2'd2;
              stage_next      = ST_START2;
              phase_step_next = 2'd0;
              scl_lvl_next    = 1'b1;
              sda_lvl_next    = 1'b1;
            end else begin
              read_index_next = '0;
              stage_next      = ST_RBITS;
              phase_step_next = 2'd0;
              bit_count_next  = 3'd7;
              shift_byte_next = 8'd0;
              sda_lvl_next    = 1'b1;
            end
          end
          ST_RBITS: begin
            if (phase_step == 2'd0) begin
              scl_lvl_next    = 1'b1;
              phase_step_next = 2'd1;
            end else if (phase_step == 2'd1) begin
              if (sda_in) begin
                shift_byte_next[bit_count] = 1'b1;
              end
              scl_lvl_next    = 1'b0;
              phase_step_next = 2'd2;
            end else if (bit_count == 3'd0) begin
              for (int i = 0; i < KEPT_BYTES; i++) begin
                if (int'(read_index) == i) begin
                  captured_next[i] = shift_byte;
                end
              end
              stage_next      = ST_RACK;
              phase_step_next = 2'd0;
              // Acknowledge every byte except the last one.
              sda_lvl_next    = (int'(read_index) + 1 < READ_BYTES) ? 1'b0 : 1'b1;
            end else begin
              bit_count_next  = bit_count - 3'd1;
              phase_step_next = 2'd0;
            end
          end
          ST_RACK: begin
            if (phase_step == 2'd0) begin
              scl_lvl_next    = 1'b1;
              phase_step_next = 2'd1;
            end else if (phase_step == 2'd1) begin
              scl_lvl_next    = 1'b0;
              phase_step_next = 2'd2;
            end else begin
              read_index_next = read_index + RIW'(1);
              phase_step_next = 2'd0;
              if (int'(read_index) + 1 < READ_BYTES) begin
                stage_next      = ST_RBITS;
                bit_count_next  = 3'd7;
                shift_byte_next = 8'd0;
                sda_lvl_next    = 1'b1;
              end else begin
                stage_next   = ST_STOP;
                sda_lvl_next = 1'b0;
              end
            end
          end
          ST_STOP: begin
            if (phase_step == 2'd0) begin
              scl_lvl_next    = 1'b1;
              phase_step_next = 2'd1;
            end else if (phase_step == 2'd1) begin
              sda_lvl_next    = 1'b1;
              phase_step_next = 2'd2;
            end else begin
              stage_next       = ST_IDLE;
              phase_step_next  = 2'd0;
              scl_lvl_next     = 1'b1;
              sda_lvl_next     = 1'b1;
              done_now         = 1'b1;
              last_status_next = nack_seen;
              if (!nack_seen) begin
                if (captured[0] != 8'd0) begin
                  touching_next = 1'b1;
                  event_now     = EV_TOUCH;
                end else if (touching) begin
                  touching_next = 1'b0;
                  event_now     = EV_RELEASE;
                end
              end
            end
          end
          ST_IDLE: begin
            stage_next = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= ST_IDLE;
      phase_step  <= 2'd0;
      bit_count   <= 3'd7;
      shift_byte  <= 8'd0;
      read_index  <= '0;
      delay_count <= 16'd0;
      for (int i = 0; i < KEPT_BYTES; i++) begin
        captured[i] <= 8'd0;
      end
      touching    <= 1'b0;
      scl_lvl     <= 1'b1;
      sda_lvl     <= 1'b1;
      write_sel   <= 2'd0;
      nack_seen   <= 1'b0;
      last_status <= 1'b0;
    end else if (step) begin
      stage       <= stage_next;
      phase_step  <= phase_step_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      read_index  <= read_index_next;
      delay_count <= delay_count_next;
      captured    <= captured_next;
      touching    <= touching_next;
      scl_lvl     <= scl_lvl_next;
      sda_lvl     <= sda_lvl_next;
      write_sel   <= write_sel_next;
      nack_seen   <= nack_seen_next;
      last_status <= last_status_next;
    end
  end

  // Result of this request as seen after the step.
  always_comb begin
    res.scl_release   = scl_lvl_next;
    res.sda_release   = sda_lvl_next;
    res.busy_res      = (stage_next != ST_IDLE);
    res.done_res      = done_now;
    res.status        = last_status_next;
    res.status_byte   = captured_next[0];
    res.position_byte = captured_next[1];
    res.extra_byte    = captured_next[2];
    res.touch_event   = event_now;
  end

`ifndef SYNTHESIS
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    stage == ST_IDLE |-> scl_lvl && sda_lvl)
    else $error("bus lines not released while idle");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_step != 2'd3)
    else $error("phase step out of range");

  a_event_with_done: assert property (@(posedge clk) disable iff (rst)
    event_now != EV_NONE |-> done_now && !nack_seen)
    else $error("touch event without a clean finish");

  // After a clean finish the touch state follows the first byte read.
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && done_now && !nack_seen |=>
      (stage == ST_IDLE) && (touching == (captured[0] != 8'd0)))
    else $error("finish did not return to idle with matching touch state");
`endif

endmodule
